@@ src/msc_pkg.sv @@
// Shared types and constants for the min-sum check-node update block.
// No dependencies; imported by min_sum_check_node_update.
package msc_pkg;

    // Row and message geometry
    localparam int ROW_DEGREE = 40;
    localparam int MSG_BITS   = 8;
    localparam int MAG_BITS   = MSG_BITS - 1;
    localparam int POS_BITS   = 6;
    localparam int SCALE_BITS = 3;
    localparam int PROD_BITS  = SCALE_BITS + MAG_BITS;

    localparam logic [MAG_BITS-1:0]   MAX_MAG     = {MAG_BITS{1'b1}};
    localparam logic [POS_BITS-1:0]   LAST_POS    = POS_BITS'(ROW_DEGREE - 1);
    localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(3);

    // Register map (word index, taken from paddr[2])
    localparam logic REG_SCALE = 1'b0;

    // Input word
    typedef struct packed {
        logic signed [MSG_BITS-1:0] message_in;
        logic                       last_in;
    } in_word_t;

    // Output word
    typedef struct packed {
        logic signed [MSG_BITS-1:0] message_out;
        logic [POS_BITS-1:0]        branch;
        logic                       last_out;
    } out_word_t;

endpackage

@@ src/msc_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while rd_en is low. No package dependency.
module msc_ram #(
    parameter int DEPTH = 40,
    parameter int WIDTH = 1,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/min_sum_check_node_update.sv @@
// Top level of the normalized min-sum check-node update.
// Depends on msc_pkg (types, constants) and msc_ram (branch sign store).
//
// Usage:
//   Input channel (in_valid/in_stall/in_word) takes one LLR word per cycle
//   while a row streams in. The word with last_in set, or the ROW_DEGREE-th
//   word, closes the row.
//   After the close the block emits one output word per branch, in order,
//   on out_valid/out_stall/out_word, with last_out on the final one.
//   After the closing input word is accepted, the first output word passes the
//   read stage and output register; then one word per cycle unless stalled.
//   Throughput: one input word per cycle during a row; a row keeps in_stall
//   high while its signs are read back from the single-port-read sign RAM,
//   one entry per cycle; receiver stalls stretch that window.
//   A stalled receiver freezes the output register and the read stage; the
//   sign RAM read is held off until a slot frees up.
//   Reset sets the running minima to MAX_MAG, clears the sign product, branch
//   count and output valid, and sets scale_quarters to 3. The sign RAM needs
//   no clear: only entries written in the current row are read.
//   scale_quarters sits at APB byte address 0; the user writes it only while idle, the block does not enforce this.
module min_sum_check_node_update
    import msc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_word,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_word,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic {ST_COLLECT, ST_EMIT} state_t;

    state_t                state_reg;
    logic [SCALE_BITS-1:0] scale_reg;
    logic [MAG_BITS-1:0]   least_reg;
    logic [MAG_BITS-1:0]   second_reg;
    logic [POS_BITS-1:0]   least_pos_reg;
    logic                  sign_prod_reg;
    logic [POS_BITS-1:0]   count_reg;
    logic [POS_BITS-1:0]   idx_reg;
    logic                  rd_vld_reg;
    logic                  out_valid_reg;

    // read stage and output payload
    logic [MAG_BITS-1:0]   rd_excl_reg;
    logic [POS_BITS-1:0]   rd_idx_reg;
    logic                  rd_last_reg;
    logic                  rd_sp_reg;
    out_word_t             out_word_reg;

    logic                  in_accept;
    logic                  cfg_write;
    logic                  msg_neg;
    logic [MSG_BITS-1:0]   msg_abs;
    logic [MAG_BITS-1:0]   msg_mag;
    logic                  row_close;
    logic                  out_free;
    logic                  issue;
    logic                  issue_last;
    logic                  sign_bit;
    logic [PROD_BITS-1:0]  prod;
    logic [MSG_BITS-1:0]   scaled;
    logic [MAG_BITS-1:0]   sat_mag;
    logic [MSG_BITS-1:0]   signed_val;

    // Handshakes
    assign in_stall  = (state_reg == ST_EMIT);
    assign in_accept = in_valid && !in_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_SCALE) ? 32'(scale_reg) : 32'd0;

    // Input magnitude, -128 clamps to 127
    assign msg_neg = in_word.message_in[MSG_BITS-1];
    assign msg_abs = msg_neg ? (~in_word.message_in + 1'b1) : in_word.message_in;
    assign msg_mag = msg_abs[MSG_BITS-1] ? MAX_MAG : msg_abs[MAG_BITS-1:0];
    assign row_close = in_word.last_in || (count_reg == LAST_POS);

    // Emit pipeline control: read stage feeds the output register
    assign out_free   = !out_valid_reg || !out_stall;
    assign issue      = (state_reg == ST_EMIT) && (!rd_vld_reg || out_free);
    assign issue_last = (idx_reg == count_reg);

    // Branch sign store
    msc_ram #(
        .DEPTH (ROW_DEGREE),
        .WIDTH (1)
    ) u_sign_ram (
        .clk     (clk),
        .wr_en   (in_accept),
        .wr_addr (count_reg),
        .wr_data (msg_neg),
        .rd_en   (issue),
        .rd_addr (idx_reg),
        .rd_data (sign_bit)
    );

    // Output value: scale, truncate, saturate, apply sign
    assign prod       = PROD_BITS'(rd_excl_reg) * PROD_BITS'(scale_reg);
    assign scaled     = prod[PROD_BITS-1:2];
    assign sat_mag    = scaled[MSG_BITS-1] ? MAX_MAG : scaled[MAG_BITS-1:0];
    assign signed_val = (rd_sp_reg ^ sign_bit) ? (~{1'b0, sat_mag} + 1'b1)
                                               : {1'b0, sat_mag};

    // State, row accumulators and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            scale_reg     <= SCALE_RESET;
            least_reg     <= MAX_MAG;
            second_reg    <= MAX_MAG;
            least_pos_reg <= '0;
            sign_prod_reg <= 1'b0;
            count_reg     <= '0;
            idx_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && (paddr[2] == REG_SCALE))
            begin
                scale_reg <= pwdata[SCALE_BITS-1:0];
            end

            unique case (state_reg)
                ST_COLLECT:
                begin
                    if (in_accept)
                    begin
                        if (msg_mag < least_reg)
                        begin
                            second_reg    <= least_reg;
                            least_reg     <= msg_mag;
                            least_pos_reg <= count_reg;
                        end
                        else if (msg_mag < second_reg)
                        begin
                            second_reg <= msg_mag;
                        end
                        sign_prod_reg <= sign_prod_reg ^ msg_neg;
                        if (row_close)
                        begin
                            state_reg <= ST_EMIT;
                            idx_reg   <= '0;
                        end
                        else
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (issue)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        if (issue_last)
                        begin
                            state_reg     <= ST_COLLECT;
                            least_reg     <= MAX_MAG;
                            second_reg    <= MAX_MAG;
                            least_pos_reg <= '0;
                            sign_prod_reg <= 1'b0;
                            count_reg     <= '0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_COLLECT;
                end
            endcase

            // read stage occupancy
            if (issue)
            begin
                rd_vld_reg <= 1'b1;
            end
            else if (out_free)
            begin
                rd_vld_reg <= 1'b0;
            end

            // output register occupancy
            if (out_free)
            begin
                out_valid_reg <= rd_vld_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_excl_reg <= (idx_reg == least_pos_reg) ? second_reg : least_reg;
            rd_idx_reg  <= idx_reg;
            rd_last_reg <= issue_last;
            rd_sp_reg   <= sign_prod_reg;
        end
        if (out_free && rd_vld_reg)
        begin
            out_word_reg.message_out <= signed_val;
            out_word_reg.branch      <= rd_idx_reg;
            out_word_reg.last_out    <= rd_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LAST_POS)
        else $error("branch count beyond row degree");

    a_min_order: assert property (@(posedge clk) disable iff (!rst_n)
        least_reg <= second_reg)
        else $error("least magnitude above second magnitude");

    a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg && !out_free |=> rd_vld_reg && $stable(rd_idx_reg))
        else $error("read stage lost while output stalled");

    a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
        issue && issue_last |=> state_reg == ST_COLLECT && count_reg == '0)
        else $error("row did not close after final read");

endmodule
